// ===== rtl/core/acc_pkg.sv =====
// Shared types, constants and a helper function for the arc collision distance pipeline.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package acc_pkg;

   // Iteration counts and pipeline depths
   localparam int ANGLE_ITERATIONS = 24;
   localparam int ROOT_W           = 64;
   localparam int ISQRT_STEPS      = ROOT_W;
   localparam int RAD_W            = 2 * ROOT_W;
   localparam int REM_W            = ROOT_W + 2;
   localparam int FRONT_STAGES     = 9;
   localparam int NORM_STAGES      = 2;
   localparam int BACK_STAGES      = 5;
   localparam int LATENCY          = FRONT_STAGES + ISQRT_STEPS + NORM_STAGES
                                     + ANGLE_ITERATIONS + BACK_STAGES;

   // Field widths
   localparam int RR_W   = 31;
   localparam int DIST_W = 35;
   localparam int CW     = 34;
   localparam int NORM_W = 30;

   // Result status codes
   localparam logic [1:0] ST_AHEAD  = 2'd0;
   localparam logic [1:0] ST_INSIDE = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   // Angles are fractions of a full turn, 2^32 per turn
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [63:0] PI_Q62    = 64'hC90F_DAA2_2168_C235;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [31:0] turn_radius;
      logic signed [31:0] obstacle_x;
      logic signed [31:0] obstacle_y;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DIST_W-1:0] distance;
   } rsp_type;

   // Side data from the geometry front end through the square root
   typedef struct packed {
      logic [1:0]  status;
      logic        ar_neg;
      logic [31:0] r;
      logic        ox_neg;
      logic [31:0] vxm;
      logic        vy_pos;
      logic [31:0] vym;
      logic        kneg;
      logic [63:0] km;
   } side_type;

   // Angles and side data into the distance back end
   typedef struct packed {
      logic [1:0]  status;
      logic        ar_neg;
      logic [31:0] r;
      logic [31:0] alpha;
      logic [31:0] thv;
   } angle_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          z;
   } cordic_type;

   // One CORDIC vectoring step, floor shifts
   function automatic cordic_type cordic_step(cordic_type c, logic [4:0] i);
      cordic_type n;
      if (c.y > 0) begin
         n.x = c.x + (c.y >>> i);
         n.y = c.y - (c.x >>> i);
         n.z = c.z + ATAN_TURNS[i];
      end else begin
         n.x = c.x - (c.y >>> i);
         n.y = c.y + (c.x >>> i);
         n.z = c.z - ATAN_TURNS[i];
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/acc_front.sv =====
// Geometry front end: magnitudes, squares, range checks and the radicand 4*d2*r2 - k^2.
// Depends on acc_pkg.
module acc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  acc_pkg::req_type             in_data,
   input  logic [acc_pkg::RR_W-1:0]     robot_radius,
   output logic                         out_valid,
   output acc_pkg::side_type            out_side,
   output logic [acc_pkg::RAD_W-1:0]    out_rad
);

   typedef struct packed {
      logic        zero;
      logic        ar_neg;
      logic        ox_neg;
      logic        vy_pos;
      logic [31:0] oxm;
      logic [31:0] oym;
      logic [31:0] r;
      logic [31:0] vym;
      logic [31:0] rr;
      logic [31:0] sum;
      logic [31:0] dif;
   } s1_type;

   typedef struct packed {
      logic        zero;
      logic        ar_neg;
      logic        ox_neg;
      logic        vy_pos;
      logic [31:0] r;
      logic [31:0] oxm;
      logic [31:0] vym;
      logic [63:0] oxm2;
      logic [63:0] oym2;
      logic [63:0] vym2;
      logic [63:0] r2;
      logic [63:0] rr2;
      logic [63:0] sum2;
      logic [63:0] dif2;
   } s2_type;

   typedef struct packed {
      logic        zero;
      logic        ar_neg;
      logic        ox_neg;
      logic        vy_pos;
      logic [31:0] r;
      logic [31:0] oxm;
      logic [31:0] vym;
      logic [64:0] ob2;
      logic [64:0] d2f;
      logic [64:0] rdiff;
      logic [63:0] r2;
      logic [63:0] rr2;
      logic [63:0] sum2;
      logic [63:0] dif2;
   } s3_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        ar_neg;
      logic        ox_neg;
      logic        vy_pos;
      logic [31:0] r;
      logic [31:0] oxm;
      logic [31:0] vym;
      logic [66:0] kv;
      logic [63:0] d2;
      logic [63:0] r2;
   } s4_type;

   typedef struct packed {
      acc_pkg::side_type side;
      logic [63:0]       d2;
      logic [63:0]       r2;
   } s5_type;

   typedef struct packed {
      acc_pkg::side_type side;
      logic [63:0]       a00;
      logic [63:0]       a01;
      logic [63:0]       a10;
      logic [63:0]       a11;
      logic [63:0]       k00;
      logic [63:0]       k01;
      logic [63:0]       k10;
      logic [63:0]       k11;
   } s6_type;

   typedef struct packed {
      acc_pkg::side_type        side;
      logic [acc_pkg::RAD_W-1:0] a4;
      logic [acc_pkg::RAD_W-1:0] k2;
   } s7_type;

   typedef struct packed {
      acc_pkg::side_type        side;
      logic [acc_pkg::RAD_W-1:0] rad;
   } s8_type;

   logic [acc_pkg::FRONT_STAGES-1:0] vld_ff;
   acc_pkg::req_type                 d0_ff;
   logic [acc_pkg::RR_W-1:0]         rr0_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;
   s8_type s8_in, s8_ff;

   logic [31:0] ar_u, ox_u, oy_u;
   logic [32:0] vy_w;
   logic [127:0] dr, kk;
   logic [66:0]  kabs;

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[acc_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   // Stage 1: magnitudes, offset from the path center, radius sum and difference
   assign ar_u = d0_ff.turn_radius;
   assign ox_u = d0_ff.obstacle_x;
   assign oy_u = d0_ff.obstacle_y;
   assign vy_w = {oy_u[31], oy_u} - {ar_u[31], ar_u};

   always_comb begin
      s1_in.zero   = (ar_u == 32'd0);
      s1_in.ar_neg = ar_u[31];
      s1_in.ox_neg = ox_u[31];
      s1_in.vy_pos = !vy_w[32] && (vy_w != 33'd0);
      s1_in.oxm    = ox_u[31] ? (32'd0 - ox_u) : ox_u;
      s1_in.oym    = oy_u[31] ? (32'd0 - oy_u) : oy_u;
      s1_in.r      = ar_u[31] ? (32'd0 - ar_u) : ar_u;
      s1_in.vym    = vy_w[32] ? 32'(33'd0 - vy_w) : vy_w[31:0];
      s1_in.rr     = {1'b0, rr0_ff};
      s1_in.sum    = s1_in.r + s1_in.rr;
      s1_in.dif    = (s1_in.r > s1_in.rr) ? (s1_in.r - s1_in.rr) : (s1_in.rr - s1_in.r);
   end

   // Stage 2: squares
   always_comb begin
      s2_in.zero   = s1_ff.zero;
      s2_in.ar_neg = s1_ff.ar_neg;
      s2_in.ox_neg = s1_ff.ox_neg;
      s2_in.vy_pos = s1_ff.vy_pos;
      s2_in.r      = s1_ff.r;
      s2_in.oxm    = s1_ff.oxm;
      s2_in.vym    = s1_ff.vym;
      s2_in.oxm2   = 64'(s1_ff.oxm) * 64'(s1_ff.oxm);
      s2_in.oym2   = 64'(s1_ff.oym) * 64'(s1_ff.oym);
      s2_in.vym2   = 64'(s1_ff.vym) * 64'(s1_ff.vym);
      s2_in.r2     = 64'(s1_ff.r) * 64'(s1_ff.r);
      s2_in.rr2    = 64'(s1_ff.rr) * 64'(s1_ff.rr);
      s2_in.sum2   = 64'(s1_ff.sum) * 64'(s1_ff.sum);
      s2_in.dif2   = 64'(s1_ff.dif) * 64'(s1_ff.dif);
   end

   // Stage 3: squared distances and the radius term of k
   always_comb begin
      s3_in.zero   = s2_ff.zero;
      s3_in.ar_neg = s2_ff.ar_neg;
      s3_in.ox_neg = s2_ff.ox_neg;
      s3_in.vy_pos = s2_ff.vy_pos;
      s3_in.r      = s2_ff.r;
      s3_in.oxm    = s2_ff.oxm;
      s3_in.vym    = s2_ff.vym;
      s3_in.ob2    = {1'b0, s2_ff.oxm2} + {1'b0, s2_ff.oym2};
      s3_in.d2f    = {1'b0, s2_ff.oxm2} + {1'b0, s2_ff.vym2};
      s3_in.rdiff  = {1'b0, s2_ff.r2} - {1'b0, s2_ff.rr2};
      s3_in.r2     = s2_ff.r2;
      s3_in.rr2    = s2_ff.rr2;
      s3_in.sum2   = s2_ff.sum2;
      s3_in.dif2   = s2_ff.dif2;
   end

   // Stage 4: classify the transaction and form k = d2 + r2 - R2
   always_comb begin
      if (s3_ff.zero) begin
         s4_in.status = acc_pkg::ST_ZERO;
      end else if (s3_ff.ob2 <= {1'b0, s3_ff.rr2}) begin
         s4_in.status = acc_pkg::ST_INSIDE;
      end else if (s3_ff.d2f[64] || (s3_ff.d2f[63:0] > s3_ff.sum2) ||
                   (s3_ff.d2f[63:0] < s3_ff.dif2) || (s3_ff.d2f == 65'd0)) begin
         s4_in.status = acc_pkg::ST_CLEAR;
      end else begin
         s4_in.status = acc_pkg::ST_AHEAD;
      end
      s4_in.ar_neg = s3_ff.ar_neg;
      s4_in.ox_neg = s3_ff.ox_neg;
      s4_in.vy_pos = s3_ff.vy_pos;
      s4_in.r      = s3_ff.r;
      s4_in.oxm    = s3_ff.oxm;
      s4_in.vym    = s3_ff.vym;
      s4_in.kv     = {2'b00, s3_ff.d2f} + {{2{s3_ff.rdiff[64]}}, s3_ff.rdiff};
      s4_in.d2     = s3_ff.d2f[63:0];
      s4_in.r2     = s3_ff.r2;
   end

   // Stage 5: sign and magnitude of k
   assign kabs = s4_ff.kv[66] ? (67'd0 - s4_ff.kv) : s4_ff.kv;
   always_comb begin
      s5_in.side.status = s4_ff.status;
      s5_in.side.ar_neg = s4_ff.ar_neg;
      s5_in.side.r      = s4_ff.r;
      s5_in.side.ox_neg = s4_ff.ox_neg;
      s5_in.side.vxm    = s4_ff.oxm;
      s5_in.side.vy_pos = s4_ff.vy_pos;
      s5_in.side.vym    = s4_ff.vym;
      s5_in.side.kneg   = s4_ff.kv[66];
      s5_in.side.km     = kabs[63:0];
      s5_in.d2          = s4_ff.d2;
      s5_in.r2          = s4_ff.r2;
   end

   // Stage 6: partial products of d2*r2 and k*k
   always_comb begin
      s6_in.side = s5_ff.side;
      s6_in.a00  = 64'(s5_ff.d2[31:0])  * 64'(s5_ff.r2[31:0]);
      s6_in.a01  = 64'(s5_ff.d2[31:0])  * 64'(s5_ff.r2[63:32]);
      s6_in.a10  = 64'(s5_ff.d2[63:32]) * 64'(s5_ff.r2[31:0]);
      s6_in.a11  = 64'(s5_ff.d2[63:32]) * 64'(s5_ff.r2[63:32]);
      s6_in.k00  = 64'(s5_ff.side.km[31:0])  * 64'(s5_ff.side.km[31:0]);
      s6_in.k01  = 64'(s5_ff.side.km[31:0])  * 64'(s5_ff.side.km[63:32]);
      s6_in.k10  = 64'(s5_ff.side.km[63:32]) * 64'(s5_ff.side.km[31:0]);
      s6_in.k11  = 64'(s5_ff.side.km[63:32]) * 64'(s5_ff.side.km[63:32]);
   end

   // Stage 7: sum the partial products
   assign dr = 128'(s6_ff.a00) + (128'(s6_ff.a01) << 32) + (128'(s6_ff.a10) << 32)
               + (128'(s6_ff.a11) << 64);
   assign kk = 128'(s6_ff.k00) + (128'(s6_ff.k01) << 32) + (128'(s6_ff.k10) << 32)
               + (128'(s6_ff.k11) << 64);
   always_comb begin
      s7_in.side = s6_ff.side;
      s7_in.a4   = dr << 2;
      s7_in.k2   = kk;
   end

   // Stage 8: radicand; a negative one means the circles miss
   always_comb begin
      s8_in.side = s7_ff.side;
      s8_in.rad  = s7_ff.a4 - s7_ff.k2;
      if ((s7_ff.side.status == acc_pkg::ST_AHEAD) && (s7_ff.a4 < s7_ff.k2)) begin
         s8_in.side.status = acc_pkg::ST_CLEAR;
      end
   end

   // Hold the payload registers
   always_ff @(posedge clock) begin
      d0_ff  <= in_data;
      rr0_ff <= robot_radius;
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      s5_ff  <= s5_in;
      s6_ff  <= s6_in;
      s7_ff  <= s7_in;
      s8_ff  <= s8_in;
   end

   assign out_valid = vld_ff[acc_pkg::FRONT_STAGES-1];
   assign out_side  = s8_ff.side;
   assign out_rad   = s8_ff.rad;

endmodule

// ===== rtl/core/acc_isqrt.sv =====
// Pipelined floor integer square root, one root bit per stage, with side data riding along.
// Depends on acc_pkg.
module acc_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  acc_pkg::side_type             in_side,
   input  logic [acc_pkg::RAD_W-1:0]     in_rad,
   output logic                          out_valid,
   output acc_pkg::side_type             out_side,
   output logic [acc_pkg::ROOT_W-1:0]    out_root
);

   typedef struct packed {
      acc_pkg::side_type          side;
      logic [acc_pkg::RAD_W-1:0]  rad;
      logic [acc_pkg::REM_W-1:0]  rem;
      logic [acc_pkg::ROOT_W-1:0] root;
   } sq_type;

   sq_type st_ff  [acc_pkg::ISQRT_STEPS];
   sq_type src    [acc_pkg::ISQRT_STEPS];
   logic   vld_ff [acc_pkg::ISQRT_STEPS];
   logic   src_v  [acc_pkg::ISQRT_STEPS];

   assign src[0]   = '{side: in_side, rad: in_rad, rem: '0, root: '0};
   assign src_v[0] = in_valid;

   genvar k;
   generate
      for (k = 0; k < acc_pkg::ISQRT_STEPS; k++) begin : g_step
         logic [acc_pkg::REM_W+1:0] rs, tr;
         sq_type nxt;

         if (k > 0) begin : g_link
            assign src[k]   = st_ff[k-1];
            assign src_v[k] = vld_ff[k-1];
         end

         // Bring down the next radicand pair and try the trial subtract
         always_comb begin
            rs  = {src[k].rem, src[k].rad[2*(acc_pkg::ISQRT_STEPS-1-k) +: 2]};
            tr  = {2'b00, src[k].root, 2'b01};
            nxt = src[k];
            if (rs >= tr) begin
               nxt.rem  = acc_pkg::REM_W'(rs - tr);
               nxt.root = {src[k].root[acc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               nxt.rem  = rs[acc_pkg::REM_W-1:0];
               nxt.root = {src[k].root[acc_pkg::ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= src_v[k];
            end
         end

         always_ff @(posedge clock) begin
            st_ff[k] <= nxt;
         end
      end
   endgenerate

   assign out_valid = vld_ff[acc_pkg::ISQRT_STEPS-1];
   assign out_side  = st_ff[acc_pkg::ISQRT_STEPS-1].side;
   assign out_root  = st_ff[acc_pkg::ISQRT_STEPS-1].root;

endmodule

// ===== rtl/core/acc_angle.sv =====
// Two-lane atan2: operand normalization then pipelined CORDIC vectoring, one step per stage.
// Depends on acc_pkg (CORDIC step, arctangent table, side types).
module acc_angle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  acc_pkg::side_type             in_side,
   input  logic [acc_pkg::ROOT_W-1:0]    in_root,
   output logic                          out_valid,
   output acc_pkg::angle_type            out_angle
);

   localparam int ANG_STAGES = acc_pkg::NORM_STAGES + acc_pkg::ANGLE_ITERATIONS;

   typedef struct packed {
      acc_pkg::side_type          side;
      logic [acc_pkg::ROOT_W-1:0] root;
      logic [6:0]                 len_a;
      logic [6:0]                 len_t;
   } n1_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                ar_neg;
      logic [31:0]         r;
      logic                za;
      logic                zt;
      acc_pkg::cordic_type ca;
      acc_pkg::cordic_type ct;
   } cp_type;

   // Bit length of a 64-bit word
   function automatic logic [6:0] bit_length(logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int b = 0; b < 64; b++) begin
         if (v[b]) begin
            n = 7'(b + 1);
         end
      end
      return n;
   endfunction

   // Shift so the larger magnitude lands just below 2^NORM_W
   function automatic logic [acc_pkg::NORM_W-1:0] norm_mag(logic [63:0] m, logic [6:0] len);
      logic [63:0] s;
      if (len > 7'(acc_pkg::NORM_W)) begin
         s = m >> (len - 7'(acc_pkg::NORM_W));
      end else begin
         s = m << (7'(acc_pkg::NORM_W) - len);
      end
      return s[acc_pkg::NORM_W-1:0];
   endfunction

   // Fold the left half plane onto the right one
   function automatic acc_pkg::cordic_type cordic_init(logic yneg,
                                                       logic [acc_pkg::NORM_W-1:0] ym,
                                                       logic xneg,
                                                       logic [acc_pkg::NORM_W-1:0] xm);
      acc_pkg::cordic_type  c;
      logic                 flip;
      logic signed [acc_pkg::CW-1:0] yp;
      flip = xneg && (xm != '0);
      yp   = $signed({{(acc_pkg::CW-acc_pkg::NORM_W){1'b0}}, ym});
      c.x  = $signed({{(acc_pkg::CW-acc_pkg::NORM_W){1'b0}}, xm});
      c.y  = (yneg ^ flip) ? -yp : yp;
      c.z  = flip ? acc_pkg::HALF_TURN : 32'd0;
      return c;
   endfunction

   logic [ANG_STAGES-1:0] vld_ff;
   n1_type n1_in, n1_ff;
   cp_type cp_ff [acc_pkg::ANGLE_ITERATIONS+1];
   cp_type cp0_in;
   logic [63:0] ym_a, xm_a, ym_t, xm_t;

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ANG_STAGES-2:0], in_valid};
      end
   end

   // Stage N1: find the normalizing shift of each lane
   always_comb begin
      n1_in.side  = in_side;
      n1_in.root  = in_root;
      n1_in.len_a = bit_length(in_root | in_side.km);
      n1_in.len_t = bit_length({32'd0, in_side.vxm | in_side.vym});
   end

   // Stage N2: apply the shift and load the CORDIC lanes
   assign ym_a = n1_ff.root;
   assign xm_a = n1_ff.side.km;
   assign ym_t = {32'd0, n1_ff.side.vxm};
   assign xm_t = {32'd0, n1_ff.side.vym};
   always_comb begin
      cp0_in.status = n1_ff.side.status;
      cp0_in.ar_neg = n1_ff.side.ar_neg;
      cp0_in.r      = n1_ff.side.r;
      cp0_in.za     = (n1_ff.len_a == 7'd0);
      cp0_in.zt     = (n1_ff.len_t == 7'd0);
      cp0_in.ca     = cordic_init(1'b0, norm_mag(ym_a, n1_ff.len_a),
                                  n1_ff.side.kneg, norm_mag(xm_a, n1_ff.len_a));
      cp0_in.ct     = cordic_init(n1_ff.side.ox_neg, norm_mag(ym_t, n1_ff.len_t),
                                  n1_ff.side.vy_pos, norm_mag(xm_t, n1_ff.len_t));
   end

   always_ff @(posedge clock) begin
      n1_ff    <= n1_in;
      cp_ff[0] <= cp0_in;
   end

   // Rotate both lanes one CORDIC step per stage
   genvar k;
   generate
      for (k = 0; k < acc_pkg::ANGLE_ITERATIONS; k++) begin : g_rot
         cp_type nxt;
         always_comb begin
            nxt    = cp_ff[k];
            nxt.ca = acc_pkg::cordic_step(cp_ff[k].ca, 5'(k));
            nxt.ct = acc_pkg::cordic_step(cp_ff[k].ct, 5'(k));
         end
         always_ff @(posedge clock) begin
            cp_ff[k+1] <= nxt;
         end
      end
   endgenerate

   // Drop the angle of a degenerate lane to zero
   always_comb begin
      out_angle.status = cp_ff[acc_pkg::ANGLE_ITERATIONS].status;
      out_angle.ar_neg = cp_ff[acc_pkg::ANGLE_ITERATIONS].ar_neg;
      out_angle.r      = cp_ff[acc_pkg::ANGLE_ITERATIONS].r;
      out_angle.alpha  = cp_ff[acc_pkg::ANGLE_ITERATIONS].za ? 32'd0
                         : cp_ff[acc_pkg::ANGLE_ITERATIONS].ca.z;
      out_angle.thv    = cp_ff[acc_pkg::ANGLE_ITERATIONS].zt ? 32'd0
                         : cp_ff[acc_pkg::ANGLE_ITERATIONS].ct.z;
   end

   assign out_valid = vld_ff[ANG_STAGES-1];

endmodule

// ===== rtl/core/acc_back.sv =====
// Distance back end: touch angles, smallest turn, |r| * angle * 2*pi with rounding.
// Depends on acc_pkg.
module acc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  acc_pkg::angle_type   in_angle,
   output logic                 out_valid,
   output acc_pkg::rsp_type     out_data
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] r;
      logic [31:0] mn;
   } b1_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] rm;
   } b2_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } b3_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] hi;
   } b4_type;

   logic [acc_pkg::BACK_STAGES-1:0] vld_ff;
   b1_type b1_in, b1_ff;
   b2_type b2_in, b2_ff;
   b3_type b3_in, b3_ff;
   b4_type b4_in, b4_ff;
   acc_pkg::rsp_type b5_in, b5_ff;
   logic [31:0]  t1, t2;
   logic [127:0] prod;
   logic [63:0]  rnd;

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[acc_pkg::BACK_STAGES-2:0], in_valid};
      end
   end

   // Stage B1: both touch angles, mirrored for a right turn, keep the smaller
   always_comb begin
      t1 = in_angle.thv + in_angle.alpha;
      t2 = in_angle.thv - in_angle.alpha;
      if (in_angle.ar_neg) begin
         t1 = acc_pkg::HALF_TURN - t1;
         t2 = acc_pkg::HALF_TURN - t2;
      end
      b1_in.status = in_angle.status;
      b1_in.r      = in_angle.r;
      b1_in.mn     = (t1 < t2) ? t1 : t2;
   end

   // Stage B2: radius times angle
   always_comb begin
      b2_in.status = b1_ff.status;
      b2_in.rm     = 64'(b1_ff.r) * 64'(b1_ff.mn);
   end

   // Stage B3: partial products against pi
   always_comb begin
      b3_in.status = b2_ff.status;
      b3_in.p00    = 64'(b2_ff.rm[31:0])  * 64'(acc_pkg::PI_Q62[31:0]);
      b3_in.p01    = 64'(b2_ff.rm[31:0])  * 64'(acc_pkg::PI_Q62[63:32]);
      b3_in.p10    = 64'(b2_ff.rm[63:32]) * 64'(acc_pkg::PI_Q62[31:0]);
      b3_in.p11    = 64'(b2_ff.rm[63:32]) * 64'(acc_pkg::PI_Q62[63:32]);
   end

   // Stage B4: sum and keep the upper half
   assign prod = 128'(b3_ff.p00) + (128'(b3_ff.p01) << 32) + (128'(b3_ff.p10) << 32)
                 + (128'(b3_ff.p11) << 64);
   always_comb begin
      b4_in.status = b3_ff.status;
      b4_in.hi     = prod[127:64];
   end

   // Stage B5: round half up; zero the distance unless a collision lies ahead
   assign rnd = b4_ff.hi + (64'd1 << 28);
   always_comb begin
      b5_in.status   = b4_ff.status;
      b5_in.distance = (b4_ff.status == acc_pkg::ST_AHEAD) ? rnd[63:29] : '0;
   end

   always_ff @(posedge clock) begin
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
      b4_ff <= b4_in;
      b5_ff <= b5_in;
   end

   assign out_valid = vld_ff[acc_pkg::BACK_STAGES-1];
   assign out_data  = b5_ff;

endmodule

// ===== rtl/core/arc_circle_collision_distance_top.sv =====
// Top level of the arc versus disc collision distance pipeline.
// Depends on acc_pkg, acc_front, acc_isqrt, acc_angle and acc_back.
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         start && !busy
//   result    rsp_strobe, rsp_data         out        strobe, one cycle, no hold-off
//   config    csr_wr_en, csr_wr_data       in         write on csr_wr_en
//
// One transaction enters every cycle; its result reaches the ports after passing 9
// geometry stages, 64 square-root stages of one root bit each, 2 normalize and
// 24 CORDIC stages, and 5 distance stages.
// busy stays low: the pipeline never stalls since the receiver takes every result.
// Synchronous reset clears all valid bits and the robot radius to zero.
module arc_circle_collision_distance_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  acc_pkg::req_type          req_data,
   output logic                      rsp_strobe,
   output acc_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [acc_pkg::RR_W-1:0]  csr_wr_data
);

   logic [acc_pkg::RR_W-1:0]   robot_radius_ff;
   logic                       fr_valid, sq_valid, an_valid;
   acc_pkg::side_type          fr_side, sq_side;
   logic [acc_pkg::RAD_W-1:0]  fr_rad;
   logic [acc_pkg::ROOT_W-1:0] sq_root;
   acc_pkg::angle_type         an_angle;

   // Hold the robot radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         robot_radius_ff <= '0;
      end else if (csr_wr_en) begin
         robot_radius_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   acc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .in_data      (req_data),
      .robot_radius (robot_radius_ff),
      .out_valid    (fr_valid),
      .out_side     (fr_side),
      .out_rad      (fr_rad)
   );

   acc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_rad    (fr_rad),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   acc_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (an_valid),
      .out_angle (an_angle)
   );

   acc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (an_valid),
      .in_angle  (an_angle),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/core/acc_checker.sv =====
// Port-level checks on the collision distance top level, attached by bind.
// Depends on acc_pkg and arc_circle_collision_distance_top.
module acc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input acc_pkg::req_type req_data,
   input logic             rsp_strobe,
   input acc_pkg::rsp_type rsp_data
);

   // Reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // Every taken transaction gives a result at the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(acc_pkg::LATENCY) rsp_strobe)
      else $error("transaction lost in the pipeline");

   // No result without a transaction taken that long ago
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, acc_pkg::LATENCY))
      else $error("result without a transaction");

   // Distance is zero unless a collision lies ahead
   a_distance_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != acc_pkg::ST_AHEAD)) |-> (rsp_data.distance == '0))
      else $error("nonzero distance with non-collision status");

   // Zero radius status only for a zero radius request
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == acc_pkg::ST_ZERO))
      |-> $past(req_data.turn_radius == 32'sd0, acc_pkg::LATENCY))
      else $error("zero radius status for a nonzero radius");

endmodule

bind arc_circle_collision_distance_top acc_checker u_acc_checker (.*);

// ===== tb/sv/arc_circle_collision_distance_checker.sv =====
// Scoreboard for the arc collision distance block: predicts each result and compares it.
// Depends on acc_pkg for the payload types, status codes and the CORDIC angle table.
module arc_circle_collision_distance_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  acc_pkg::req_type          req_data,
   input  logic                      rsp_strobe,
   input  acc_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [acc_pkg::RR_W-1:0]  csr_wr_data,
   output int                        fail_count,
   output int                        pending
);

   acc_pkg::rsp_type contact_q [$];
   logic [30:0]      robot_rad;

   // Heading of (x, y) as a fraction of a full turn, by CORDIC vectoring
   function automatic logic [31:0] turn_angle(bit yneg, logic [63:0] ym,
                                              bit xneg, logic [63:0] xm);
      longint      x, y, nx;
      logic [31:0] z;
      int          i;
      z = '0;
      while (ym >= (64'd1 << 30) || xm >= (64'd1 << 30)) begin
         ym = ym >> 1;
         xm = xm >> 1;
      end
      if (ym == 0 && xm == 0) return '0;
      while (ym < (64'd1 << 29) && xm < (64'd1 << 29)) begin
         ym = ym << 1;
         xm = xm << 1;
      end
      x = xneg ? -longint'(xm) : longint'(xm);
      y = yneg ? -longint'(ym) : longint'(ym);
      // fold the left half plane onto the right one
      if (x < 0) begin
         x = -x;
         y = -y;
         z = acc_pkg::HALF_TURN;
      end
      for (i = 0; i < acc_pkg::ANGLE_ITERATIONS && i < 32; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + acc_pkg::ATAN_TURNS[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - acc_pkg::ATAN_TURNS[i];
         end
         x = nx;
      end
      return z;
   endfunction

   // Travel along the arc before the robot disc touches the obstacle
   function automatic acc_pkg::rsp_type predict_contact(acc_pkg::req_type q, logic [30:0] rr);
      longint      ar, ox, oy, vy;
      logic [63:0] oxm, oym, r, vxm, vym, dx2, d2, sum, dif, r2, rr2, p, km, h, cand, hi;
      bit          kneg;
      logic [127:0] a4, k2, rem, prod;
      logic [31:0] thv, alpha, t1, t2, mn;
      acc_pkg::rsp_type res;
      res = '0;
      ar  = longint'(q.turn_radius);
      ox  = longint'(q.obstacle_x);
      oy  = longint'(q.obstacle_y);
      if (ar == 0) begin
         res.status = acc_pkg::ST_ZERO;
         return res;
      end
      oxm = ox < 0 ? -ox : ox;
      oym = oy < 0 ? -oy : oy;
      rr2 = {33'd0, rr} * {33'd0, rr};
      if (oxm * oxm + oym * oym <= rr2) begin
         res.status = acc_pkg::ST_INSIDE;
         return res;
      end
      r   = ar < 0 ? -ar : ar;
      vy  = oy - ar;
      vxm = oxm;
      vym = vy < 0 ? -vy : vy;
      // 64-bit wrap is part of the behavior here
      dx2 = vxm * vxm;
      d2  = dx2 + vym * vym;
      sum = r + {33'd0, rr};
      dif = r > {33'd0, rr} ? r - {33'd0, rr} : {33'd0, rr} - r;
      if (d2 < dx2 || d2 > sum * sum || d2 < dif * dif || d2 == 0) begin
         res.status = acc_pkg::ST_CLEAR;
         return res;
      end
      r2 = r * r;
      p  = d2 + r2;
      if (p < d2 || p >= rr2) begin
         kneg = 1'b0;
         km   = p - rr2;
      end else begin
         kneg = 1'b1;
         km   = rr2 - p;
      end
      a4 = ({64'd0, d2} * {64'd0, r2}) << 2;
      k2 = {64'd0, km} * {64'd0, km};
      if (a4 < k2) begin
         res.status = acc_pkg::ST_CLEAR;
         return res;
      end
      // floor square root, one bit at a time
      rem = a4 - k2;
      h   = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = h | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= rem) h = cand;
      end
      alpha = turn_angle(1'b0, h, kneg, km);
      thv   = turn_angle(ox < 0, vxm, vy > 0, vym);
      t1 = thv + alpha;
      t2 = thv - alpha;
      // mirror for a right turn
      if (ar < 0) begin
         t1 = acc_pkg::HALF_TURN - t1;
         t2 = acc_pkg::HALF_TURN - t2;
      end
      mn   = t1 < t2 ? t1 : t2;
      prod = {64'd0, r * {32'd0, mn}} * {64'd0, acc_pkg::PI_Q62};
      hi   = prod[127:64];
      hi   = (hi + (64'd1 << 28)) >> 29;
      res.status   = acc_pkg::ST_AHEAD;
      res.distance = hi[acc_pkg::DIST_W-1:0];
      return res;
   endfunction

   // Predict on each accepted transaction, compare each result, track the register
   always @(posedge clock) begin
      acc_pkg::rsp_type exp_rsp;
      if (reset) begin
         robot_rad = '0;
         contact_q.delete();
         fail_count = 0;
      end else begin
         if (start && !busy) contact_q.push_back(predict_contact(req_data, robot_rad));
         if (rsp_strobe) begin
            if (contact_q.size() == 0) begin
               $error("unexpected result: status %0d distance %0h",
                      rsp_data.status, rsp_data.distance);
               fail_count++;
            end else begin
               exp_rsp = contact_q.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.distance !== exp_rsp.distance) begin
                  $error("distance: expected %0h, actual %0h",
                         exp_rsp.distance, rsp_data.distance);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) robot_rad = csr_wr_data;
      end
      pending = contact_q.size();
   end

endmodule

// ===== tb/sv/arc_circle_collision_distance_top_tb.sv =====
// Stimulus and verdict for the arc collision distance block.
// Depends on acc_pkg, the block's top level and arc_circle_collision_distance_checker.
module arc_circle_collision_distance_top_tb;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   acc_pkg::req_type req_data;
   logic             rsp_strobe;
   acc_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [30:0]      csr_wr_data;
   int               fail_count;
   int               pending;
   int               burst_left;

   arc_circle_collision_distance_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   arc_circle_collision_distance_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Present one transaction, hold it until taken, idle between bursts
   task automatic send_query(logic [31:0] ar, logic [31:0] ox, logic [31:0] oy);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_data <= '{turn_radius: ar, obstacle_x: ox, obstacle_y: oy};
      start    <= 1'b1;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   // Write the robot radius once the pipeline has drained
   task automatic set_radius(logic [30:0] rad);
      start <= 1'b0;
      @(posedge clock);
      forever begin
         @(negedge clock);
         if (pending == 0) break;
      end
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rad;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random query: mostly scaled near the path circle, some full-range noise
   task automatic random_query();
      logic [31:0] ar, ox, oy;
      int          sh;
      sh = $urandom_range(4, 30);
      ar = $urandom;
      ox = $urandom;
      oy = $urandom;
      if ($urandom_range(0, 4) != 0) begin
         ar = $signed(ar) >>> (31 - sh);
         ox = $signed(ox) >>> (30 - sh);
         oy = $signed(oy) >>> (30 - sh);
         if ($urandom_range(0, 3) == 0) oy = oy + ar;
      end
      if ($urandom_range(0, 60) == 0) ar = '0;
      send_query(ar, ox, oy);
   endtask

   initial begin
      logic [30:0] radii [5];
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      burst_left  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed cases at a one-metre robot
      set_radius(31'h0001_0000);
      send_query(32'd0, 32'h0005_0000, 32'h0001_0000);
      send_query(32'h0002_0000, 32'd0, 32'd0);
      send_query(32'h0002_0000, 32'd0, 32'h0002_0000);
      send_query(32'h0002_0000, 32'd0, 32'h0005_0000);
      send_query(32'h0002_0000, 32'd0, 32'h0002_8000);
      send_query(32'h0002_0000, 32'h0003_0000, 32'h0002_0000);
      send_query(32'hFFFE_0000, 32'h0003_0000, 32'hFFFE_0000);
      send_query(32'hFFFE_0000, 32'hFFFD_0000, 32'hFFFE_0000);
      send_query(32'h0002_0000, 32'hFFFD_0000, 32'h0002_0000);
      send_query(32'h0002_0000, 32'h0020_0000, 32'h0020_0000);
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h7FFF_FFFF, 32'h0100_0000, 32'h0000_0000);
      send_query(32'h8000_0000, 32'h0100_0000, 32'hFFFF_0000);
      send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_query(32'h0000_0001, 32'h0001_0000, 32'h0000_0001);
      send_query(32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_8000);

      radii = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'h0000_0100, 31'($urandom)};
      foreach (radii[k]) begin
         set_radius(radii[k]);
         repeat (290) random_query();
      end

      // drain, then give the verdict
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (pending == 0) break;
      end
      repeat (acc_pkg::LATENCY + 20) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
